// ===== rtl/wpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsd_pkg
// Shared widths, result kinds and header tags of the WAV PCM stream deframer.
// ----------------------------------------------------------------------------
package wpsd_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int SAMPLE_W   = 24;
  localparam int CHAN_W     = 16;
  localparam int RATE_W     = 32;
  localparam int DEPTH_W    = 16;
  localparam int SIZE_W     = 32;
  localparam int OUT_BITS_W = 5;

  // Packed result data: sample, channels, sample_rate, sample_bits, data_size
  localparam int M_DATA_W = SAMPLE_W + CHAN_W + RATE_W + DEPTH_W + SIZE_W;

  // Default internal sample width and register reset value
  localparam int                    OUT_WIDTH_DEF = 24;
  localparam logic [OUT_BITS_W-1:0] OUT_BITS_RST  = 5'd16;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FORMAT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NOT_RIFF = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_WAVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOT_PCM  = 3'd4;

  // Header tags, first byte in the top bits
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [15:0] FMT_PCM  = 16'h0100;

  // Fixed header byte positions
  localparam logic [5:0] POS_RIFF_END = 6'd3;
  localparam logic [5:0] POS_WAVE_END = 6'd11;
  localparam logic [5:0] POS_FMT_END  = 6'd21;
  localparam logic [5:0] POS_CHAN_LO  = 6'd22;
  localparam logic [5:0] POS_CHAN_HI  = 6'd23;
  localparam logic [5:0] POS_RATE_LO  = 6'd24;
  localparam logic [5:0] POS_RATE_HI  = 6'd27;
  localparam logic [5:0] POS_DEPTH_LO = 6'd34;
  localparam logic [5:0] POS_DEPTH_HI = 6'd35;

  // 8-bit PCM zero offset and the one wide depth
  localparam logic [7:0]  PCM8_OFFSET = 8'h80;
  localparam logic [15:0] DEPTH_WIDE  = 16'd16;

endpackage

// ===== rtl/wav_pcm_stream_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// wav_pcm_stream_deframer_unit
// Parses a WAV byte stream: checks the fixed header, skips chunks up to the
// data chunk, reports the format once, then emits one mono sample per frame.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  s_*      in   tdata: data_byte   tuser: restart                tvalid/tready
//  m_*      out  tdata: sample..data_size   tuser: kind           tvalid/tready
//  cfg_*    in   cfg_data: out_bits                               cfg_valid/ready
//
//  One input item per clock; a byte's result appears in the output register
//  the cycle after it is accepted.
//  The only bound on rate is the single output register: s_tready drops only
//  while a result is held and m_tready is low.
//  rst is synchronous: parse state clears, out_bits returns to 16.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module wav_pcm_stream_deframer_unit
  import wpsd_pkg::*;
#(
  parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                  s_tuser,   // [0] restart
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // [23:0] sample, [39:24] channels,
                                           // [71:40] sample_rate,
                                           // [87:72] sample_bits,
                                           // [119:88] data_size
  output logic [KIND_W-1:0]     m_tuser,   // [2:0] kind
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [OUT_BITS_W-1:0] cfg_data   // out_bits
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_ID,
    PH_LEN_SKIP,
    PH_LEN_DATA,
    PH_SKIP,
    PH_DATA,
    PH_ERROR
  } phase_t;

  localparam int MASK_BITS = (OUT_WIDTH < SAMPLE_W) ? OUT_WIDTH : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((64'(1) << MASK_BITS) - 64'(1));

  // State
  phase_t                phase;
  logic [5:0]            byte_pos;
  logic [31:0]           tag_shift;
  logic [SIZE_W-1:0]     skip_count;
  logic [CHAN_W-1:0]     chan_count;
  logic [RATE_W-1:0]     rate_value;
  logic [DEPTH_W-1:0]    depth_value;
  logic [23:0]           frame_bytes;
  logic [1:0]            frame_index;
  logic [OUT_BITS_W-1:0] out_bits;

  phase_t                phase_next;
  logic [5:0]            byte_pos_next;
  logic [31:0]           tag_shift_next;
  logic [SIZE_W-1:0]     skip_count_next;
  logic [CHAN_W-1:0]     chan_count_next;
  logic [RATE_W-1:0]     rate_value_next;
  logic [DEPTH_W-1:0]    depth_value_next;
  logic [23:0]           frame_bytes_next;
  logic [1:0]            frame_index_next;

  // Parse state as seen by this byte (restart clears it first)
  phase_t             cur_phase;
  logic [5:0]         cur_pos;
  logic [31:0]        cur_tag;
  logic [SIZE_W-1:0]  cur_skip;
  logic [CHAN_W-1:0]  cur_chan;
  logic [RATE_W-1:0]  cur_rate;
  logic [DEPTH_W-1:0] cur_depth;
  logic [23:0]        cur_frame;
  logic [1:0]         cur_index;

  // Result being formed
  logic                res_valid;
  logic [KIND_W-1:0]   res_kind;
  logic [SAMPLE_W-1:0] res_sample;
  logic                res_format;

  // Frame decode
  logic               wide, stereo, last_byte;
  logic [2:0]         need;
  logic [7:0]         fb0, fb1, fb2, fb3;
  logic signed [15:0] word_a, word_c, mono;
  logic signed [16:0] wide_sum;
  logic signed [8:0]  narrow_a, narrow_c;
  logic signed [9:0]  narrow_sum;
  logic signed [16:0] narrow_half, wide_half;

  // Depth conversion
  logic signed [17:0]   shift_d;
  logic [17:0]          shift_neg;
  logic [4:0]           right_amt;
  logic signed [SAMPLE_W-1:0] mono_ext;
  logic [SAMPLE_W-1:0]  shifted;

  logic in_fire;
  logic out_load;

  assign in_fire   = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Select the parse state this byte starts from
  always_comb begin
    if (s_tuser) begin
      cur_phase = PH_HEADER;
      cur_pos   = '0;
      cur_tag   = '0;
      cur_skip  = '0;
      cur_chan  = '0;
      cur_rate  = '0;
      cur_depth = '0;
      cur_frame = '0;
      cur_index = '0;
    end else begin
      cur_phase = phase;
      cur_pos   = byte_pos;
      cur_tag   = tag_shift;
      cur_skip  = skip_count;
      cur_chan  = chan_count;
      cur_rate  = rate_value;
      cur_depth = depth_value;
      cur_frame = frame_bytes;
      cur_index = frame_index;
    end
  end

  // Assemble the frame and form the mono sample
  always_comb begin
    wide      = (cur_depth == DEPTH_WIDE);
    stereo    = (cur_chan == CHAN_W'(2));
    need      = {1'b0, stereo, !stereo} << wide;
    last_byte = ({1'b0, cur_index} + 3'd1) >= need;
    fb0 = cur_frame[7:0];
    fb1 = cur_frame[15:8];
    fb2 = cur_frame[23:16];
    fb3 = '0;
    case (cur_index)
      2'd0:    fb0 = s_tdata;
      2'd1:    fb1 = s_tdata;
      2'd2:    fb2 = s_tdata;
      default: fb3 = s_tdata;
    endcase
    word_a      = $signed({fb1, fb0});
    word_c      = $signed({fb3, fb2});
    wide_sum    = 17'(word_a) + 17'(word_c);
    wide_half   = (wide_sum + $signed({16'd0, wide_sum[16]})) >>> 1;
    narrow_a    = $signed({1'b0, fb0}) - $signed({1'b0, PCM8_OFFSET});
    narrow_c    = $signed({1'b0, fb1}) - $signed({1'b0, PCM8_OFFSET});
    narrow_sum  = 10'(narrow_a) + 10'(narrow_c);
    narrow_half = 17'((narrow_sum + $signed({9'd0, narrow_sum[9]})) >>> 1);
    if (wide) begin
      mono = stereo ? wide_half[15:0] : word_a;
    end else begin
      mono = stereo ? narrow_half[15:0] : 16'(narrow_a);
    end
  end

  // Shift to out_bits: left, or arithmetic right, saturating large amounts
  always_comb begin
    shift_d   = $signed({13'd0, out_bits}) - $signed({2'd0, cur_depth});
    shift_neg = 18'(-shift_d);
    right_amt = (shift_neg > 18'd31) ? 5'd31 : shift_neg[4:0];
    mono_ext  = SAMPLE_W'(mono);
    if (shift_d > 18'sd0) begin
      shifted = (shift_d >= 18'(SAMPLE_W)) ? '0 : (mono_ext << shift_d[4:0]);
    end else if (shift_d < 18'sd0) begin
      shifted = mono_ext >>> right_amt;
    end else begin
      shifted = mono_ext;
    end
  end

  // Advance the parser by one byte
  always_comb begin
    phase_next       = cur_phase;
    byte_pos_next    = cur_pos;
    tag_shift_next   = cur_tag;
    skip_count_next  = cur_skip;
    chan_count_next  = cur_chan;
    rate_value_next  = cur_rate;
    depth_value_next = cur_depth;
    frame_bytes_next = cur_frame;
    frame_index_next = cur_index;
    res_valid  = 1'b0;
    res_kind   = KIND_SAMPLE;
    res_sample = '0;
    res_format = 1'b0;
    unique case (cur_phase)
      PH_HEADER: begin
        tag_shift_next = {cur_tag[23:0], s_tdata};
        if (cur_pos == POS_CHAN_LO) begin
          chan_count_next = {8'd0, s_tdata};
        end else if (cur_pos == POS_CHAN_HI) begin
          chan_count_next[15:8] = s_tdata;
        end else if (cur_pos == POS_RATE_LO) begin
          rate_value_next = {24'd0, s_tdata};
        end else if (cur_pos > POS_RATE_LO && cur_pos <= POS_RATE_HI) begin
          rate_value_next[8*cur_pos[1:0] +: 8] = cur_rate[8*cur_pos[1:0] +: 8] | s_tdata;
        end else if (cur_pos == POS_DEPTH_LO) begin
          depth_value_next = {8'd0, s_tdata};
        end else if (cur_pos == POS_DEPTH_HI) begin
          depth_value_next[15:8] = s_tdata;
        end
        if (cur_pos == POS_RIFF_END && tag_shift_next != TAG_RIFF) begin
          res_valid  = 1'b1;
          res_kind   = KIND_NOT_RIFF;
          phase_next = PH_ERROR;
        end else if (cur_pos == POS_WAVE_END && tag_shift_next != TAG_WAVE) begin
          res_valid  = 1'b1;
          res_kind   = KIND_NOT_WAVE;
          phase_next = PH_ERROR;
        end else if (cur_pos == POS_FMT_END && tag_shift_next[15:0] != FMT_PCM) begin
          res_valid  = 1'b1;
          res_kind   = KIND_NOT_PCM;
          phase_next = PH_ERROR;
        end else if (cur_pos >= POS_DEPTH_HI) begin
          phase_next    = PH_CHUNK_ID;
          byte_pos_next = '0;
        end else begin
          byte_pos_next = cur_pos + 6'd1;
        end
      end
      PH_CHUNK_ID: begin
        tag_shift_next = {cur_tag[23:0], s_tdata};
        if (cur_pos[1:0] == 2'd3) begin
          byte_pos_next   = '0;
          skip_count_next = '0;
          phase_next = (tag_shift_next == TAG_DATA) ? PH_LEN_DATA : PH_LEN_SKIP;
        end else begin
          byte_pos_next = {4'd0, cur_pos[1:0] + 2'd1};
        end
      end
      PH_LEN_SKIP, PH_LEN_DATA: begin
        skip_count_next[8*cur_pos[1:0] +: 8] = cur_skip[8*cur_pos[1:0] +: 8] | s_tdata;
        if (cur_pos[1:0] == 2'd3) begin
          byte_pos_next = '0;
          if (cur_phase == PH_LEN_DATA) begin
            phase_next       = PH_DATA;
            frame_bytes_next = '0;
            frame_index_next = '0;
            res_valid  = 1'b1;
            res_kind   = KIND_FORMAT;
            res_format = 1'b1;
          end else begin
            phase_next = (skip_count_next != '0) ? PH_SKIP : PH_CHUNK_ID;
          end
        end else begin
          byte_pos_next = {4'd0, cur_pos[1:0] + 2'd1};
        end
      end
      PH_SKIP: begin
        skip_count_next = cur_skip - SIZE_W'(1);
        if (skip_count_next == '0) begin
          phase_next = PH_CHUNK_ID;
        end
      end
      PH_DATA: begin
        if (!last_byte) begin
          frame_bytes_next = {fb2, fb1, fb0};
          frame_index_next = cur_index + 2'd1;
        end else begin
          frame_bytes_next = '0;
          frame_index_next = '0;
          res_valid  = 1'b1;
          res_kind   = KIND_SAMPLE;
          res_sample = shifted & SAMPLE_MASK;
        end
      end
      default: begin
        // error: ignore bytes until restart
      end
    endcase
  end

  assign out_load = in_fire && res_valid;

  // Hold parse state, configuration and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      byte_pos    <= '0;
      tag_shift   <= '0;
      skip_count  <= '0;
      chan_count  <= '0;
      rate_value  <= '0;
      depth_value <= '0;
      frame_bytes <= '0;
      frame_index <= '0;
      out_bits    <= OUT_BITS_RST;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        out_bits <= cfg_data;
      end
      if (in_fire) begin
        phase       <= phase_next;
        byte_pos    <= byte_pos_next;
        tag_shift   <= tag_shift_next;
        skip_count  <= skip_count_next;
        chan_count  <= chan_count_next;
        rate_value  <= rate_value_next;
        depth_value <= depth_value_next;
        frame_bytes <= frame_bytes_next;
        frame_index <= frame_index_next;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_kind;
      if (res_format) begin
        m_tdata <= {skip_count_next, cur_depth, cur_rate, cur_chan, SAMPLE_W'(0)};
      end else begin
        m_tdata <= {(M_DATA_W - SAMPLE_W)'(0), res_sample};
      end
    end
  end

endmodule

// ===== rtl/wpsd_checker.sv =====
// ----------------------------------------------------------------------------
// wpsd_checker
// Port-level checks of the WAV PCM stream deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wpsd_checker
  import wpsd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]   m_tuser
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Accept input whenever the result register is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled with free output register");

  // Header fields only travel with a format result
  a_fmt_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_FORMAT |-> m_tdata[M_DATA_W-1:SAMPLE_W] == '0)
    else $error("header fields set outside a format result");

  // Sample is zero in every non-sample result
  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_SAMPLE |-> m_tdata[SAMPLE_W-1:0] == '0)
    else $error("sample set in a non-sample result");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind wav_pcm_stream_deframer_unit wpsd_checker u_wpsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the WAV PCM stream deframer. Byte streams carrying
// WAV files (good, broken and truncated) are pushed through the slave side
// while a software copy of the parser predicts each result item; the master
// side is compared field by field. out_bits is rewritten between files.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpsd_pkg::*;

  localparam int OUT_W          = OUT_WIDTH_DEF;
  localparam int IDLE_PCT       = 33;
  localparam int SETTLE_CYCLES  = 4;     // output register plus margin
  localparam int RANDOM_ITEMS   = 40;
  // far above any idle stretch in a correct run
  localparam int WATCHDOG_LIMIT = 2000;

  // chunk tags used by the stimulus, first byte in the top bits
  localparam logic [31:0] TAG_FMT_ID = 32'h666D_7420;
  localparam logic [31:0] TAG_LIST   = 32'h4C49_5354;
  localparam logic [31:0] TAG_JUNK   = 32'h6A75_6E6B;

  typedef enum logic [2:0] {
    PS_HEADER, PS_TAG, PS_LEN_SKIP, PS_LEN_DATA, PS_SKIP, PS_DATA, PS_HALT
  } parse_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] pcm;
    logic [CHAN_W-1:0]   chans;
    logic [RATE_W-1:0]   rate;
    logic [DEPTH_W-1:0]  bits;
    logic [SIZE_W-1:0]   dsize;
  } wav_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata   = '0;   // [7:0] data_byte
  logic                  s_tuser   = 1'b0; // [0] restart
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;          // [23:0] sample, [39:24] channels,
                                           // [71:40] sample_rate,
                                           // [87:72] sample_bits,
                                           // [119:88] data_size
  logic [KIND_W-1:0]     m_tuser;          // [2:0] kind
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [OUT_BITS_W-1:0] cfg_data  = OUT_BITS_RST;

  // parser copy
  parse_state_t          ps;
  logic [5:0]            byte_pos;
  logic [31:0]           tag_sr;
  logic [31:0]           chunk_len;
  logic [15:0]           chan_q;
  logic [31:0]           rate_q;
  logic [15:0]           depth_q;
  logic [23:0]           frame_acc;
  logic [1:0]            frame_cnt;
  logic [OUT_BITS_W-1:0] width_cfg;

  wav_result_t results_due[$];
  logic [7:0]  stream_buf[$];
  int          err_count   = 0;
  int          items_sent  = 0;
  int          idle_cycles = 0;
  bit          gaps_on     = 1'b1;

  always #5 clk = ~clk;

  wav_pcm_stream_deframer_unit #(.OUT_WIDTH(OUT_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------- parser

  function automatic void clear_parse();
    ps        = PS_HEADER;
    byte_pos  = '0;
    tag_sr    = '0;
    chunk_len = '0;
    chan_q    = '0;
    rate_q    = '0;
    depth_q   = '0;
    frame_acc = '0;
    frame_cnt = '0;
  endfunction

  function automatic void push_result(logic [KIND_W-1:0] kind, logic [SAMPLE_W-1:0] pcm,
                                      logic [CHAN_W-1:0] chans, logic [RATE_W-1:0] rate,
                                      logic [DEPTH_W-1:0] bits, logic [SIZE_W-1:0] dsize);
    wav_result_t r;
    r = '{kind: kind, pcm: pcm, chans: chans, rate: rate, bits: bits, dsize: dsize};
    results_due.push_back(r);
  endfunction

  // shift a sample from the header depth to out_bits, clamped and wrapped
  function automatic logic [SAMPLE_W-1:0] rescale(int v);
    int                 d;
    int                 sh;
    logic signed [63:0] u;
    d = int'(width_cfg) - int'(depth_q);
    u = v;
    if (d > 0) begin
      sh = (d > OUT_W) ? OUT_W : d;
      u  = u << sh;
    end else if (d < 0) begin
      sh = (-d > OUT_W) ? OUT_W : -d;
      u  = u >>> sh;
    end
    if (OUT_W < SAMPLE_W) u = u & ((64'sd1 << OUT_W) - 1);
    return u[SAMPLE_W-1:0];
  endfunction

  // advance the parser by one accepted item and queue what it yields
  function automatic void deframe_byte(logic [7:0] b, logic rs);
    int         pos;
    int         need;
    int         i;
    int         a;
    int         c;
    int         s;
    logic [7:0] fb [4];
    bit         wide;
    bit         stereo;
    if (rs) clear_parse();
    case (ps)
      PS_HEADER: begin
        pos    = byte_pos;
        tag_sr = {tag_sr[23:0], b};
        if (pos == POS_CHAN_LO) chan_q = {8'h00, b};
        else if (pos == POS_CHAN_HI) chan_q[15:8] = b;
        else if (pos == POS_RATE_LO) rate_q = {24'h0, b};
        else if (pos > POS_RATE_LO && pos <= POS_RATE_HI)
          rate_q = rate_q | (32'(b) << (8 * (pos - POS_RATE_LO)));
        else if (pos == POS_DEPTH_LO) depth_q = {8'h00, b};
        else if (pos == POS_DEPTH_HI) depth_q[15:8] = b;
        if (pos == POS_RIFF_END && tag_sr != TAG_RIFF) begin
          push_result(KIND_NOT_RIFF, '0, '0, '0, '0, '0);
          ps = PS_HALT;
        end else if (pos == POS_WAVE_END && tag_sr != TAG_WAVE) begin
          push_result(KIND_NOT_WAVE, '0, '0, '0, '0, '0);
          ps = PS_HALT;
        end else if (pos == POS_FMT_END && tag_sr[15:0] != FMT_PCM) begin
          push_result(KIND_NOT_PCM, '0, '0, '0, '0, '0);
          ps = PS_HALT;
        end else if (pos >= POS_DEPTH_HI) begin
          ps       = PS_TAG;
          byte_pos = '0;
        end else begin
          byte_pos = 6'(pos + 1);
        end
      end
      PS_TAG: begin
        tag_sr   = {tag_sr[23:0], b};
        byte_pos = {4'b0, byte_pos[1:0]} + 6'd1;
        if (byte_pos >= 6'd4) begin
          byte_pos  = '0;
          chunk_len = '0;
          ps        = (tag_sr == TAG_DATA) ? PS_LEN_DATA : PS_LEN_SKIP;
        end
      end
      PS_LEN_SKIP, PS_LEN_DATA: begin
        pos       = byte_pos[1:0];
        chunk_len = chunk_len | (32'(b) << (8 * pos));
        byte_pos  = 6'(pos + 1);
        if (pos == 3) begin
          byte_pos = '0;
          if (ps == PS_LEN_DATA) begin
            ps        = PS_DATA;
            frame_acc = '0;
            frame_cnt = '0;
            push_result(KIND_FORMAT, '0, chan_q, rate_q, depth_q, chunk_len);
          end else begin
            ps = (chunk_len != 0) ? PS_SKIP : PS_TAG;
          end
        end
      end
      PS_SKIP: begin
        chunk_len = chunk_len - 32'd1;
        if (chunk_len == 0) ps = PS_TAG;
      end
      PS_DATA: begin
        wide   = (depth_q == DEPTH_WIDE);
        stereo = (chan_q == 16'd2);
        need   = (stereo ? 2 : 1) * (wide ? 2 : 1);
        i      = frame_cnt;
        if (i + 1 < need) begin
          frame_acc = frame_acc | (24'(b) << (8 * i));
          frame_cnt = 2'(i + 1);
        end else begin
          fb[0]     = frame_acc[7:0];
          fb[1]     = frame_acc[15:8];
          fb[2]     = frame_acc[23:16];
          fb[3]     = 8'h00;
          fb[i]     = b;
          frame_acc = '0;
          frame_cnt = '0;
          if (wide) begin
            a = int'($signed({fb[1], fb[0]}));
            s = a;
            if (stereo) begin
              c = int'($signed({fb[3], fb[2]}));
              s = (a + c) / 2;
            end
          end else begin
            s = int'(fb[0]) - int'(PCM8_OFFSET);
            if (stereo) s = (s + int'(fb[1]) - int'(PCM8_OFFSET)) / 2;
          end
          push_result(KIND_SAMPLE, rescale(s), '0, '0, '0, '0);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------- stream build

  function automatic void add_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) stream_buf.push_back(v[8*k +: 8]);
  endfunction

  function automatic void add_tag(logic [31:0] t);
    for (int k = 3; k >= 0; k--) stream_buf.push_back(t[8*k +: 8]);
  endfunction

  function automatic void add_header(logic [15:0] fmt, logic [15:0] chans,
                                     logic [31:0] rate, logic [15:0] depth);
    add_tag(TAG_RIFF);
    add_le($urandom, 4);
    add_tag(TAG_WAVE);
    add_tag(TAG_FMT_ID);
    add_le(32'd16, 4);
    add_le(fmt, 2);
    add_le(chans, 2);
    add_le(rate, 4);
    add_le($urandom, 4);
    add_le($urandom, 2);
    add_le(depth, 2);
  endfunction

  function automatic void add_chunk(logic [31:0] tag, logic [31:0] len, int body);
    add_tag(tag);
    add_le(len, 4);
    repeat (body) stream_buf.push_back(8'($urandom_range(255)));
  endfunction

  function automatic logic [15:0] pick_field(int common, int other);
    int r;
    r = $urandom_range(19);
    if (r < 10) return 16'(common);
    if (r < 17) return 16'(other);
    return 16'($urandom_range(65535));
  endfunction

  // mostly well-formed files with random content, some noise and bad tags
  function automatic void add_random_file();
    int          r;
    int          idx;
    logic [31:0] len;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(40, 1)) stream_buf.push_back(8'($urandom_range(255)));
    end else begin
      add_header(16'h0001, pick_field(2, 1), $urandom, pick_field(16, 8));
      if (r < 16) begin
        case ($urandom_range(2))
          0:       idx = $urandom_range(3);
          1:       idx = 8 + $urandom_range(3);
          default: idx = 20 + $urandom_range(1);
        endcase
        stream_buf[idx] = stream_buf[idx] ^ 8'($urandom_range(255, 1));
      end
      repeat ($urandom_range(2)) begin
        len = $urandom_range(6);
        add_chunk($urandom, len, len);
      end
      // a long chunk is cut short by the next restart
      if ($urandom_range(9) == 0) add_chunk($urandom, $urandom, $urandom_range(6));
      else add_chunk(TAG_DATA, $urandom, $urandom_range(32));
    end
  endfunction

  // -------------------------------------------------------------- drivers

  task automatic send_byte(logic [7:0] b, logic rs);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= rs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_byte(b, rs);
    items_sent++;
  endtask

  task automatic send_stream(bit mark_restart = 1'b1);
    foreach (stream_buf[k]) send_byte(stream_buf[k], mark_restart && k == 0);
    stream_buf.delete();
  endtask

  // hold input, wait for every pending result and the pipeline to empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_out_bits(logic [OUT_BITS_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_cfg = v;
  endtask

  // --------------------------------------------------------------- tests

  // first file follows reset with no restart flag; out_bits at reset value
  task automatic test_stereo16_defaults();
    add_header(16'h0001, 16'd2, 32'd44100, 16'd16);
    add_chunk(TAG_LIST, 32'd3, 3);
    add_chunk(TAG_JUNK, 32'd0, 0);       // zero-length chunk
    add_chunk(TAG_DATA, 32'd18, 0);
    add_le(32'h7FFF_7FFF, 4);
    add_le(32'h8000_8000, 4);
    add_le(32'h7FFF_8000, 4);            // -1/2 truncates to zero
    add_le(32'h0000_FFFF, 4);
    add_le(32'h1234, 2);                 // partial frame, never reported
    send_stream(1'b0);
  endtask

  task automatic test_header_errors();
    add_header(16'h0001, 16'd1, 32'd8000, 16'd8);
    stream_buf[0] = 8'h72;
    stream_buf    = stream_buf[0:7];
    send_stream();
    add_header(16'h0001, 16'd1, 32'd8000, 16'd8);
    stream_buf[11] = 8'h00;
    stream_buf     = stream_buf[0:15];
    send_stream();
    add_header(16'h0003, 16'd1, 32'd8000, 16'd8);
    stream_buf = stream_buf[0:23];
    send_stream();
    add_header(16'h0101, 16'd1, 32'd8000, 16'd8);
    add_chunk(TAG_DATA, 32'd2, 2);       // all ignored after the error
    send_stream();
  endtask

  task automatic test_frame_layouts();
    // run both sides flat out for the whole task
    gaps_on = 1'b0;
    add_header(16'h0001, 16'd1, 32'd22050, 16'd8);
    add_chunk(TAG_DATA, 32'd4, 0);
    add_le(32'h7F80_FF00, 4);
    send_stream();
    add_header(16'h0001, 16'd2, 32'd11025, 16'd8);
    add_chunk(TAG_DATA, 32'd6, 0);
    add_le(32'hFFFF_0000, 4);
    add_le(32'hFF00, 2);
    send_stream();
    add_header(16'h0001, 16'd1, 32'd48000, 16'd16);
    add_chunk(TAG_DATA, 32'd6, 0);
    add_le(32'h7FFF_8000, 4);
    add_le(32'h0001, 2);
    send_stream();
    // unusual channel counts fall back to mono
    add_header(16'h0001, 16'd0, 32'd8000, 16'd16);
    add_chunk(TAG_DATA, 32'd2, 2);
    send_stream();
    add_header(16'h0001, 16'd3, 32'd8000, 16'd8);
    add_chunk(TAG_DATA, 32'd2, 2);
    send_stream();
    // unusual depths read as 8-bit but shift by the header depth
    add_header(16'h0001, 16'd1, 32'd96000, 16'd24);
    add_chunk(TAG_DATA, 32'd2, 0);
    add_le(32'hFF00, 2);
    send_stream();
    add_header(16'h0001, 16'd2, 32'd16000, 16'd0);
    add_chunk(TAG_DATA, 32'd2, 0);
    add_le(32'hFFFF, 2);
    send_stream();
    add_header(16'h0001, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_chunk(TAG_DATA, 32'hFFFF_FFFF, 0);
    add_le(32'h7F00, 2);
    send_stream();
    gaps_on = 1'b1;
  endtask

  task automatic test_restarts();
    add_header(16'h0001, 16'd2, 32'd44100, 16'd16);
    stream_buf = stream_buf[0:19];       // cut inside the header
    send_stream();
    add_header(16'h0001, 16'd2, 32'd44100, 16'd16);
    add_tag(TAG_LIST);
    add_le(32'h10, 2);                   // cut inside a length
    send_stream();
    add_header(16'h0001, 16'd1, 32'd8000, 16'd8);
    add_chunk(TAG_LIST, 32'hFFFF_FFFF, 5);  // cut while skipping
    send_stream();
    add_header(16'h0001, 16'd2, 32'd44100, 16'd16);
    add_chunk(TAG_DATA, 32'd8, 6);       // cut mid-frame
    send_stream();
    add_header(16'h0001, 16'd2, 32'd32000, 16'd16);
    add_chunk(TAG_DATA, 32'd8, 8);
    send_stream();
  endtask

  // extreme widths, including a left shift far enough to clear the sample
  task automatic test_width_extremes();
    logic [OUT_BITS_W-1:0] widths [4];
    logic [15:0]           depths [4];
    widths = '{5'd0, 5'd1, 5'd24, 5'd31};
    depths = '{16'd16, 16'd8, 16'd16, 16'd4};
    foreach (widths[k]) begin
      write_out_bits(widths[k]);
      add_header(16'h0001, 16'd1, $urandom, depths[k]);
      if (depths[k] == DEPTH_WIDE) begin
        add_chunk(TAG_DATA, 32'd8, 0);
        add_le(32'h7FFF_8000, 4);
        add_le(32'h0001_FFFF, 4);
      end else begin
        add_chunk(TAG_DATA, 32'd2, 0);
        add_le(32'hFF00, 2);
      end
      send_stream();
    end
  endtask

  task automatic test_random_streams();
    int start;
    int files;
    start = items_sent;
    files = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (files % 6 == 0)
        write_out_bits(($urandom_range(9) < 7) ? 5'($urandom_range(24, 1))
                                                : 5'($urandom_range(31)));
      add_random_file();
      send_stream($urandom_range(9) != 0);
      files++;
    end
  endtask

  // ------------------------------------------------------ result checking

  function automatic void compare_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp, act);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    m_tready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk) begin : check_results
    wav_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d",
                 $time, m_tuser);
        err_count++;
      end else begin
        want = results_due.pop_front();
        compare_field("kind", want.kind, m_tuser);
        compare_field("sample", want.pcm, m_tdata[SAMPLE_W-1:0]);
        compare_field("channels", want.chans, m_tdata[SAMPLE_W +: CHAN_W]);
        compare_field("sample_rate", want.rate, m_tdata[SAMPLE_W+CHAN_W +: RATE_W]);
        compare_field("sample_bits", want.bits,
                      m_tdata[SAMPLE_W+CHAN_W+RATE_W +: DEPTH_W]);
        compare_field("data_size", want.dsize, m_tdata[M_DATA_W-SIZE_W +: SIZE_W]);
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    width_cfg = OUT_BITS_RST;
    clear_parse();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_stereo16_defaults();
    test_header_errors();
    test_frame_layouts();
    test_restarts();
    test_width_extremes();
    test_random_streams();
    settle();
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wpsd_pkg.sv
rtl/wav_pcm_stream_deframer_unit.sv
rtl/wpsd_checker.sv
tb/tb.sv
